FILE: rtl/whsc_pkg.sv
package whsc_pkg;

	localparam int unsigned CoordW  = 16;
	localparam int unsigned AmountW = 16;
	localparam int unsigned WeightW = 24;
	localparam int unsigned RadiusW = 12;
	localparam int unsigned DenW    = WeightW + 1;
	localparam int unsigned NumW    = CoordW + WeightW + 1;

	localparam logic [RadiusW-1:0] RadiusFloor = 12'd256;
	localparam logic [WeightW-1:0] WeightMax   = 24'hFFFFFF;

	typedef enum logic {
		CFG_MERGE_RADIUS = 1'b0,
		CFG_MIN_AMOUNT   = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [CoordW-1:0]  x;
		logic [CoordW-1:0]  z;
		logic [AmountW-1:0] amount;
		logic               last;
		logic               opens;
	} patch_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctrl_t;

endpackage

FILE: rtl/whsc_div.sv
module whsc_div
	import whsc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NumW-1:0]     num,
	input  logic [DenW-1:0]     den,
	output logic                busy,
	output logic [CoordW-1:0]   quot
);

	logic [DenW-1:0]   rem_q;
	logic [CoordW-1:0] bits_q;
	logic [DenW-1:0]   den_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic [DenW:0]     shifted;
	logic [DenW:0]     trial;
	logic              fits;

	// one restoring step: bring down the next bit and try the divisor
	always_comb begin
		shifted = {rem_q, bits_q[CoordW-1]};
		trial   = shifted - {1'b0, den_q};
		fits    = (shifted >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(CoordW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1)
				busy_q <= 1'b0;
		end
	end

	// quotient fits the coordinate width, so the top bits seed the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num[NumW-1:CoordW];
			bits_q <= num[CoordW-1:0];
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= fits ? trial[DenW-1:0] : shifted[DenW-1:0];
			bits_q <= {bits_q[CoordW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quot = bits_q;

endmodule

FILE: rtl/whsc_queue.sv
module whsc_queue
	import whsc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CoordW-1:0]  patch_x,
	input  logic [CoordW-1:0]  patch_z,
	input  logic [AmountW-1:0] patch_amount,
	input  logic               last_patch,
	input  logic [AmountW-1:0] min_amount,
	output logic               q_valid,
	input  logic               q_pop,
	output patch_t             q_head
);

	patch_t     ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	logic       push;
	patch_t     item;

	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != 2'd0);
	assign q_head   = ent_q[rd_q];

	// classify: a patch may open a hotspot only above the minimum amount
	always_comb begin
		item.x      = patch_x;
		item.z      = patch_z;
		item.amount = patch_amount;
		item.last   = last_patch;
		item.opens  = (patch_amount > min_amount);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (q_pop)
				rd_q <= ~rd_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= item;
	end

endmodule

FILE: rtl/whsc_engine.sv
module whsc_engine
	import whsc_pkg::*;
#(
	parameter int unsigned MAX_HOTSPOTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_pop,
	input  patch_t              q_head,
	input  logic [2*RadiusW-1:0] radius_sq,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CoordW-1:0]   hotspot_x,
	output logic [CoordW-1:0]   hotspot_z,
	output logic [WeightW-1:0]  hotspot_weight,
	output logic                hotspot_valid,
	output logic                table_overflow,
	output logic                last_of_run
);

	localparam int unsigned IW = (MAX_HOTSPOTS > 1) ? $clog2(MAX_HOTSPOTS) : 1;
	localparam int unsigned CW = $clog2(MAX_HOTSPOTS + 1);
	localparam logic [CW-1:0] CountMax = CW'(MAX_HOTSPOTS);
	localparam int unsigned EW = 2 * CoordW + WeightW;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_READ = 9'b000000010,
		ST_DIST = 9'b000000100,
		ST_CMP  = 9'b000001000,
		ST_MUL  = 9'b000010000,
		ST_DIV  = 9'b000100000,
		ST_APP  = 9'b001000000,
		ST_ORD  = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t                 state_q;
	patch_t                 p_q;
	logic [CW-1:0]          idx_q;
	logic [CW-1:0]          cnt_q;
	logic                   ovf_q;
	logic                   used_q;
	logic [2*CoordW-1:0]    sqx_q;
	logic [2*CoordW-1:0]    sqz_q;
	logic [NumW-2:0]        ax_q;
	logic [NumW-2:0]        az_q;
	logic [DenW-1:0]        den_q;

	logic [EW-1:0]          mem [MAX_HOTSPOTS];
	logic [EW-1:0]          rd_q;
	logic                   we;
	logic [IW-1:0]          waddr;
	logic [EW-1:0]          wdata;

	logic                   ov_q;
	logic [CoordW-1:0]      ox_q;
	logic [CoordW-1:0]      oz_q;
	logic [WeightW-1:0]     ow_q;
	logic                   ohv_q;
	logic                   oovf_q;
	logic                   olast_q;

	logic [CoordW-1:0]      tx;
	logic [CoordW-1:0]      tz;
	logic [WeightW-1:0]     tw;
	logic [CoordW-1:0]      dx;
	logic [CoordW-1:0]      dz;
	logic                   in_range;
	logic [2*CoordW-1:0]    prod_x;
	logic [2*CoordW-1:0]    prod_z;
	logic [NumW-1:0]        num_x;
	logic [NumW-1:0]        num_z;
	div_ctrl_t              div_x;
	div_ctrl_t              div_z;
	logic [CoordW-1:0]      qx;
	logic [CoordW-1:0]      qz;
	logic [CoordW-1:0]      new_x;
	logic [CoordW-1:0]      new_z;
	logic [DenW-1:0]        sum_w;
	logic [WeightW-1:0]     new_w;
	logic                   out_free;
	logic                   is_final;

	assign tx = rd_q[EW-1 -: CoordW];
	assign tz = rd_q[WeightW +: CoordW];
	assign tw = rd_q[WeightW-1:0];

	// distance terms and merge arithmetic
	always_comb begin
		dx       = (p_q.x > tx) ? (p_q.x - tx) : (tx - p_q.x);
		dz       = (p_q.z > tz) ? (p_q.z - tz) : (tz - p_q.z);
		in_range = ({1'b0, sqx_q} + {1'b0, sqz_q}) <
			{{(2*CoordW+1-2*RadiusW){1'b0}}, radius_sq};
		prod_x   = p_q.x * p_q.amount;
		prod_z   = p_q.z * p_q.amount;
		num_x    = {1'b0, ax_q} + {{(NumW-2*CoordW){1'b0}}, prod_x};
		num_z    = {1'b0, az_q} + {{(NumW-2*CoordW){1'b0}}, prod_z};
		sum_w    = {1'b0, tw} + {{(DenW-AmountW){1'b0}}, p_q.amount};
		new_w    = sum_w[DenW-1] ? WeightMax : sum_w[WeightW-1:0];
		new_x    = (den_q == '0) ? tx : qx;
		new_z    = (den_q == '0) ? tz : qz;
		out_free = !ov_q || out_ready;
		is_final = (cnt_q == '0) || (idx_q + CW'(1) == cnt_q);
	end

	assign div_x.start = (state_q == ST_MUL);
	assign div_z.start = (state_q == ST_MUL);

	whsc_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_x.start),
		.num    (num_x),
		.den    (den_q),
		.busy   (div_x.busy),
		.quot   (qx)
	);

	whsc_div u_div_z (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_z.start),
		.num    (num_z),
		.den    (den_q),
		.busy   (div_z.busy),
		.quot   (qz)
	);

	// table write port: merge back at the walk index or append at the count
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[IW-1:0];
		wdata = {new_x, new_z, new_w};
		if (state_q == ST_DIV && !div_x.busy && !div_z.busy) begin
			we = 1'b1;
		end else if (state_q == ST_APP && p_q.opens && !used_q && cnt_q < CountMax) begin
			we    = 1'b1;
			waddr = cnt_q[IW-1:0];
			wdata = {p_q.x, p_q.z, {(WeightW-AmountW){1'b0}}, p_q.amount};
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[idx_q[IW-1:0]];
	end

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			used_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			// hold the result until it transfers; load the next one from readout
			ov_q <= (ov_q && !out_ready) || (state_q == ST_OUT && out_free);
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						idx_q   <= '0;
						used_q  <= 1'b0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= (idx_q == cnt_q) ? ST_APP : ST_DIST;
				end
				ST_DIST: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (in_range) begin
						used_q  <= 1'b1;
						state_q <= ST_MUL;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= ST_READ;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!div_x.busy && !div_z.busy) begin
						idx_q   <= idx_q + CW'(1);
						state_q <= ST_READ;
					end
				end
				ST_APP: begin
					if (p_q.opens && !used_q) begin
						if (cnt_q < CountMax)
							cnt_q <= cnt_q + CW'(1);
						else
							ovf_q <= 1'b1;
					end
					idx_q   <= '0;
					state_q <= p_q.last ? ST_ORD : ST_IDLE;
				end
				ST_ORD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						if (is_final) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= ST_ORD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop)
			p_q <= q_head;
		if (state_q == ST_DIST) begin
			sqx_q <= dx * dx;
			sqz_q <= dz * dz;
		end
		if (state_q == ST_CMP) begin
			ax_q  <= tx * tw;
			az_q  <= tz * tw;
			den_q <= sum_w;
		end
		if (state_q == ST_OUT && out_free) begin
			ohv_q   <= (cnt_q != '0);
			oovf_q  <= ovf_q;
			olast_q <= is_final;
			ox_q    <= (cnt_q == '0) ? '0 : tx;
			oz_q    <= (cnt_q == '0) ? '0 : tz;
			ow_q    <= (cnt_q == '0) ? '0 : tw;
		end
	end

	assign out_valid      = ov_q;
	assign hotspot_x      = ox_q;
	assign hotspot_z      = oz_q;
	assign hotspot_weight = ow_q;
	assign hotspot_valid  = ohv_q;
	assign table_overflow = oovf_q;
	assign last_of_run    = olast_q;

endmodule

FILE: rtl/weighted_hotspot_clustering_unit.sv
// channel | direction | transfer when          | payload
// in      | in        | in_valid & in_ready    | patch_x, patch_z, patch_amount, last_patch
// out     | out       | out_valid & out_ready  | hotspot_x/z/weight/valid, table_overflow,
//         |           |                        | last_of_run
// cfg     | in        | cfg_valid & cfg_ready  | cfg_index, cfg_data (always ready)
//
// A patch is walked against every stored hotspot in turn; a hotspot in range merges
// it through two 16-step serial dividers that run side by side, and a patch that
// merges with none may be appended to the table.
// Readout walks the table hotspot by hotspot.
// A two-entry queue accepts patches until it is full while the table walk or readout stalls.
// Reset gives radius 256, minimum amount 64, an empty table and a clear overflow flag.
module weighted_hotspot_clustering_unit
	import whsc_pkg::*;
#(
	parameter int unsigned MAX_HOTSPOTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CoordW-1:0]  patch_x,
	input  logic [CoordW-1:0]  patch_z,
	input  logic [AmountW-1:0] patch_amount,
	input  logic               last_patch,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CoordW-1:0]  hotspot_x,
	output logic [CoordW-1:0]  hotspot_z,
	output logic [WeightW-1:0] hotspot_weight,
	output logic               hotspot_valid,
	output logic               table_overflow,
	output logic               last_of_run,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	logic [RadiusW-1:0]   radius_q;
	logic [AmountW-1:0]   min_q;
	logic [2*RadiusW-1:0] r2_q;
	logic [RadiusW-1:0]   r_eff;
	logic                 q_valid;
	logic                 q_pop;
	patch_t               q_head;

	assign cfg_ready = 1'b1;

	// hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RadiusFloor;
			min_q    <= 16'd64;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_MERGE_RADIUS: radius_q <= cfg_data[RadiusW-1:0];
				CFG_MIN_AMOUNT:   min_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	// square the floored radius in a register, off the walk path
	assign r_eff = (radius_q < RadiusFloor) ? RadiusFloor : radius_q;

	always_ff @(posedge clk) begin
		r2_q <= r_eff * r_eff;
	end

	whsc_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.patch_x      (patch_x),
		.patch_z      (patch_z),
		.patch_amount (patch_amount),
		.last_patch   (last_patch),
		.min_amount   (min_q),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_head       (q_head)
	);

	whsc_engine #(
		.MAX_HOTSPOTS (MAX_HOTSPOTS)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_pop          (q_pop),
		.q_head         (q_head),
		.radius_sq      (r2_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hotspot_x      (hotspot_x),
		.hotspot_z      (hotspot_z),
		.hotspot_weight (hotspot_weight),
		.hotspot_valid  (hotspot_valid),
		.table_overflow (table_overflow),
		.last_of_run    (last_of_run)
	);

endmodule

FILE: dv/tb_top.sv
module tb_top;
	import whsc_pkg::*;

	localparam int unsigned TableDepth = 64;
	localparam int unsigned SettleCycles = 300;
	localparam int unsigned IdleLimit = 20000;

	typedef struct {
		logic [CoordW-1:0]  x;
		logic [CoordW-1:0]  z;
		logic [WeightW-1:0] weight;
		logic               valid;
		logic               overflow;
		logic               last;
	} hotspot_t;

	// mirror of the hotspot table plus the queue of readout entries still owed
	class cluster_scoreboard;
		logic [CoordW-1:0]  spot_x[TableDepth];
		logic [CoordW-1:0]  spot_z[TableDepth];
		logic [WeightW-1:0] spot_w[TableDepth];
		int unsigned        spot_cnt;
		bit                 ovf;
		logic [RadiusW-1:0] radius;
		logic [15:0]        min_amt;
		hotspot_t           owed[$];
		int unsigned        errors;
		int unsigned        checked;
		int unsigned        patches;

		function new();
			radius = RadiusFloor;
			min_amt = 16'd64;
			spot_cnt = 0;
			ovf = 0;
			errors = 0;
			checked = 0;
			patches = 0;
		endfunction

		function void set_reg(cfg_index_t idx, logic [15:0] data);
			if (idx == CFG_MERGE_RADIUS)
				radius = data[RadiusW-1:0];
			else
				min_amt = data;
		endfunction

		function logic [CoordW-1:0] blend(logic [CoordW-1:0] a, longint unsigned wa,
				logic [CoordW-1:0] b, longint unsigned wb);
			longint unsigned den;
			longint unsigned num;
			den = wa + wb;
			if (den == 0)
				return a;
			num = a * wa + b * wb;
			return CoordW'(num / den);
		endfunction

		// fold one accepted patch into the table; queue the readout on a last patch
		function void note_patch(logic [CoordW-1:0] px, logic [CoordW-1:0] pz,
				logic [AmountW-1:0] amt, logic last);
			longint unsigned r;
			longint unsigned dx;
			longint unsigned dz;
			longint unsigned total;
			bit hit;
			hotspot_t h;
			patches++;
			r = (radius < RadiusFloor) ? RadiusFloor : radius;
			hit = 0;
			for (int j = 0; j < spot_cnt; j++) begin
				dx = (px > spot_x[j]) ? px - spot_x[j] : spot_x[j] - px;
				dz = (pz > spot_z[j]) ? pz - spot_z[j] : spot_z[j] - pz;
				if (dx * dx + dz * dz < r * r) begin
					hit = 1;
					total = spot_w[j] + amt;
					spot_x[j] = blend(spot_x[j], spot_w[j], px, amt);
					spot_z[j] = blend(spot_z[j], spot_w[j], pz, amt);
					spot_w[j] = (total > WeightMax) ? WeightMax : WeightW'(total);
				end
			end
			if (!hit && amt > min_amt) begin
				if (spot_cnt < TableDepth) begin
					spot_x[spot_cnt] = px;
					spot_z[spot_cnt] = pz;
					spot_w[spot_cnt] = amt;
					spot_cnt++;
				end else begin
					ovf = 1;
				end
			end
			if (!last)
				return;
			if (spot_cnt == 0) begin
				h = '{x: '0, z: '0, weight: '0, valid: 1'b0, overflow: ovf, last: 1'b1};
				owed = {owed, h};
			end else begin
				for (int j = 0; j < spot_cnt; j++) begin
					h = '{x: spot_x[j], z: spot_z[j], weight: spot_w[j], valid: 1'b1,
						overflow: ovf, last: (j == spot_cnt - 1)};
					owed = {owed, h};
				end
			end
			spot_cnt = 0;
			ovf = 0;
		endfunction

		function void check_hotspot(hotspot_t got);
			hotspot_t exp_h;
			checked++;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: unexpected hotspot x=%0d z=%0d w=%0d", $time, got.x, got.z,
					got.weight);
				return;
			end
			exp_h = owed.pop_front();
			if (got.x !== exp_h.x) begin
				errors++;
				$display("%0t: hotspot_x expected %0d actual %0d", $time, exp_h.x, got.x);
			end
			if (got.z !== exp_h.z) begin
				errors++;
				$display("%0t: hotspot_z expected %0d actual %0d", $time, exp_h.z, got.z);
			end
			if (got.weight !== exp_h.weight) begin
				errors++;
				$display("%0t: hotspot_weight expected %0d actual %0d", $time, exp_h.weight,
					got.weight);
			end
			if (got.valid !== exp_h.valid) begin
				errors++;
				$display("%0t: hotspot_valid expected %0b actual %0b", $time, exp_h.valid,
					got.valid);
			end
			if (got.overflow !== exp_h.overflow) begin
				errors++;
				$display("%0t: table_overflow expected %0b actual %0b", $time, exp_h.overflow,
					got.overflow);
			end
			if (got.last !== exp_h.last) begin
				errors++;
				$display("%0t: last_of_run expected %0b actual %0b", $time, exp_h.last,
					got.last);
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [CoordW-1:0]  patch_x = '0;
	logic [CoordW-1:0]  patch_z = '0;
	logic [AmountW-1:0] patch_amount = '0;
	logic               last_patch = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic [CoordW-1:0]  hotspot_x;
	logic [CoordW-1:0]  hotspot_z;
	logic [WeightW-1:0] hotspot_weight;
	logic               hotspot_valid;
	logic               table_overflow;
	logic               last_of_run;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic               cfg_index = 0;
	logic [15:0]        cfg_data = '0;

	cluster_scoreboard sb = new();
	bit   send_busy = 1;
	bit   long_hold_req = 0;
	int   idle_cycles = 0;

	weighted_hotspot_clustering_unit dut (.*);

	always #5 clk = ~clk;

	// receiver: random stall per result, bursts without stalls, one long hold-off
	int   hold = 0;
	int   recv_since_flip = 0;
	bit   recv_busy = 1;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				sb.check_hotspot('{x: hotspot_x, z: hotspot_z, weight: hotspot_weight,
					valid: hotspot_valid, overflow: table_overflow, last: last_of_run});
				recv_since_flip++;
				if (recv_since_flip > $urandom_range(10, 30)) begin
					recv_busy = !recv_busy;
					recv_since_flip = 0;
				end
				hold = recv_busy ? $urandom_range(0, 17) : 0;
				if (long_hold_req) begin
					hold = 3000;
					long_hold_req = 0;
				end
				out_ready <= (hold == 0);
			end else if (hold > 0) begin
				hold--;
				out_ready <= (hold == 0);
			end else begin
				out_ready <= 1;
			end
		end
	end

	// watchdog on cycles with no transfer on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic send_patch(logic [CoordW-1:0] px, logic [CoordW-1:0] pz,
			logic [AmountW-1:0] amt, logic last);
		int gap;
		gap = send_busy ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		patch_x <= px;
		patch_z <= pz;
		patch_amount <= amt;
		last_patch <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_patch(px, pz, amt, last);
	endtask

	// pause the sender until every owed hotspot has come and the block settles
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [15:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	// random patches: mostly clusters round a few centres, some full-range noise
	task automatic random_burst(int n);
		logic [CoordW-1:0] cx[4];
		logic [CoordW-1:0] cz[4];
		int k;
		for (int c = 0; c < 4; c++) begin
			cx[c] = CoordW'($urandom);
			cz[c] = CoordW'($urandom);
		end
		for (int i = 0; i < n; i++) begin
			if (i % 20 == 0)
				send_busy = $urandom_range(0, 2) != 0;
			if ($urandom_range(0, 4) == 0) begin
				send_patch(CoordW'($urandom), CoordW'($urandom), AmountW'($urandom),
					$urandom_range(0, 7) == 0);
			end else begin
				k = $urandom_range(0, 3);
				send_patch(CoordW'(cx[k] + $urandom_range(0, 600) - 300),
					CoordW'(cz[k] + $urandom_range(0, 600) - 300),
					AmountW'($urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom),
					$urandom_range(0, 9) == 0);
			end
		end
		send_patch(CoordW'($urandom), CoordW'($urandom), AmountW'($urandom), 1);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty readout, extremes, opening threshold, merges, distance edge
		send_patch(16'd5, 16'd5, 16'd0, 1);
		send_patch(16'd0, 16'd0, 16'hFFFF, 0);
		send_patch(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
		send_patch(16'd20000, 16'd20000, 16'd64, 0);
		send_patch(16'd30000, 16'd30000, 16'd65, 0);
		send_patch(16'd30100, 16'd30050, 16'd300, 0);
		send_patch(16'd30200, 16'd29990, 16'd0, 0);
		send_patch(16'd40000, 16'd40000, 16'd1000, 0);
		send_patch(16'd40256, 16'd40000, 16'd500, 0);
		send_patch(16'd40255, 16'd40000, 16'd700, 0);
		send_patch(16'd50000, 16'd10000, 16'd900, 0);
		send_patch(16'd50300, 16'd10000, 16'd900, 0);
		send_patch(16'd50150, 16'd10000, 16'd77, 1);
		drain();

		// radius register extremes; upper data bits must be ignored
		write_reg(CFG_MERGE_RADIUS, 16'hF000);
		write_reg(CFG_MIN_AMOUNT, 16'd0);
		send_patch(16'd1000, 16'd1000, 16'd1, 0);
		send_patch(16'd1200, 16'd1000, 16'd0, 0);
		send_patch(16'd3000, 16'd1000, 16'd0, 1);
		drain();
		write_reg(CFG_MERGE_RADIUS, 16'd4095);
		write_reg(CFG_MIN_AMOUNT, 16'hFFFF);
		send_patch(16'd100, 16'd100, 16'hFFFF, 0);
		send_patch(16'd4000, 16'd100, 16'hFFFF, 1);
		drain();

		// fill the table past its depth to raise the overflow flag
		write_reg(CFG_MERGE_RADIUS, 16'd256);
		write_reg(CFG_MIN_AMOUNT, 16'd64);
		send_busy = 0;
		for (int i = 0; i < TableDepth + 2; i++)
			send_patch(16'((i % 16) * 4096), 16'((i / 16) * 4096), 16'd1000,
				i == TableDepth + 1);
		drain();

		// long receiver hold-off mid readout while the sender keeps offering patches
		long_hold_req = 1;
		for (int i = 0; i < 8; i++)
			send_patch(16'(i * 6000), 16'd3000, 16'd800, i == 3);

		// random part under several settings
		send_busy = 1;
		random_burst(55);
		drain();
		write_reg(CFG_MERGE_RADIUS, 16'd1500);
		write_reg(CFG_MIN_AMOUNT, 16'd200);
		random_burst(55);
		drain();
		write_reg(CFG_MERGE_RADIUS, 16'($urandom_range(0, 4095)));
		write_reg(CFG_MIN_AMOUNT, 16'($urandom_range(0, 1000)));
		random_burst(55);
		drain();

		$display("Sent %0d patches over config sweeps, table overflow and a long output stall;",
			sb.patches);
		$display("checked %0d hotspot results with %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/whsc_pkg.sv
rtl/whsc_div.sv
rtl/whsc_queue.sv
rtl/whsc_engine.sv
rtl/weighted_hotspot_clustering_unit.sv
dv/tb_top.sv
